// ===== design/gws_pkg.sv =====
package gws_pkg;
    localparam int MaxDim = 32;
    localparam int DimW = $clog2(MaxDim);
    localparam int CellW = 2 * DimW;
    localparam int Cells = MaxDim * MaxDim;
    localparam int MaxWord = 64;
    localparam int WordIdxW = $clog2(MaxWord);
    localparam int WordLenW = $clog2(MaxWord + 1);
    localparam int SizeW = 6;
    localparam logic [7:0] SpaceChar = 8'h20;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_WORD = 2'd1,
        K_READ = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]      kind;
        logic [DimW-1:0] row;
        logic [DimW-1:0] col;
        logic [7:0]      ch;
        logic            last;
    } t_item;

    typedef struct packed {
        logic            found;
        logic [DimW-1:0] start_row;
        logic [DimW-1:0] start_col;
        logic [2:0]      direction;
        logic [7:0]      cell_char;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DISPATCH,
        S_READ_WAIT,
        S_READ_MARK,
        S_DIR,
        S_FETCH,
        S_CMP,
        S_MARK,
        S_EMIT
    } t_state;

    function automatic logic signed [1:0] dir_dr(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd1, 3'd2: v = -2'sd1;
            3'd3, 3'd4:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dc(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd3, 3'd5: v = -2'sd1;
            3'd1, 3'd6:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction
endpackage

// ===== design/gws_ram.sv =====
module gws_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/gws_fifo.sv =====
module gws_fifo import gws_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);
    t_item      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rp];
endmodule

// ===== design/gws_front.sv =====
module gws_front import gws_pkg::*; (
    input  logic            i_push,
    output logic            o_full,
    input  logic [1:0]      i_kind,
    input  logic [DimW-1:0] i_row,
    input  logic [DimW-1:0] i_col,
    input  logic [7:0]      i_ch,
    input  logic            i_last,
    output logic            o_q_push,
    output t_item           o_q_data,
    input  logic            i_q_full
);
    logic accept;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept && (i_kind != K_NONE);
    assign o_q_data = '{kind: i_kind, row: i_row, col: i_col, ch: i_ch, last: i_last};
endmodule

// ===== design/gws_back.sv =====
module gws_back import gws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_item            i_q_data,
    output logic             o_q_pop,
    input  logic [SizeW-1:0] i_grid_size,
    output logic             o_empty,
    input  logic             i_pop,
    output t_result          o_res,
    output logic             o_idle
);
    t_state r_state, n_state;
    t_item  r_it, n_it;
    logic [WordLenW-1:0] r_len, n_len;
    logic                r_ovf, n_ovf;
    logic [CellW-1:0]    r_clr, n_clr;
    logic [DimW-1:0]     r_r, n_r, r_c, n_c;
    logic [2:0]          r_d, n_d;
    logic [WordIdxW-1:0] r_k, n_k;
    logic signed [DimW+1:0] r_pr, n_pr, r_pc, n_pc;
    logic                r_ovalid, n_ovalid;
    t_result             r_res, n_res;
    logic [DimW:0]       dim;

    logic              g_we, m_we, w_we;
    logic [CellW-1:0]  g_ra, m_wa, m_ra;
    logic [7:0]        g_rd, w_rd;
    logic              m_wd, m_rd;
    logic [WordIdxW-1:0] w_wa, w_ra;

    gws_ram #(.Width(8), .Depth(Cells)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_waddr({i_q_data.row, i_q_data.col}),
        .i_wdata(i_q_data.ch), .i_raddr(g_ra), .o_rdata(g_rd));
    gws_ram #(.Width(1), .Depth(Cells)) u_mark (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));
    gws_ram #(.Width(8), .Depth(MaxWord)) u_word (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(i_q_data.ch),
        .i_raddr(w_ra), .o_rdata(w_rd));

    logic signed [DimW+1:0] er, ec, lm1;
    logic [CellW-1:0]       pcell;

    always_comb begin
        if (i_grid_size == '0) begin
            dim = (DimW+1)'(1);
        end else if (i_grid_size > SizeW'(MaxDim)) begin
            dim = (DimW+1)'(MaxDim);
        end else begin
            dim = i_grid_size[DimW:0];
        end
        lm1   = (DimW+2)'(r_len - 1'b1);
        er    = $signed({2'b00, r_r}) + (dir_dr(r_d) * lm1);
        ec    = $signed({2'b00, r_c}) + (dir_dc(r_d) * lm1);
        pcell = {r_pr[DimW-1:0], r_pc[DimW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_it  <= n_it;
        r_r   <= n_r;
        r_c   <= n_c;
        r_d   <= n_d;
        r_k   <= n_k;
        r_pr  <= n_pr;
        r_pc  <= n_pc;
        r_res <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_it     = r_it;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_clr    = r_clr;
        n_r      = r_r;
        n_c      = r_c;
        n_d      = r_d;
        n_k      = r_k;
        n_pr     = r_pr;
        n_pc     = r_pc;
        n_ovalid = r_ovalid;
        n_res    = r_res;
        o_q_pop  = 1'b0;
        g_we     = 1'b0;
        m_we     = 1'b0;
        m_wa     = pcell;
        m_wd     = 1'b1;
        w_we     = 1'b0;
        w_wa     = r_len[WordIdxW-1:0];
        g_ra     = pcell;
        m_ra     = pcell;
        w_ra     = r_k;
        if (r_ovalid && i_pop) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                m_we  = 1'b1;
                m_wa  = r_clr;
                m_wd  = 1'b0;
                n_clr = r_clr + 1'b1;
                if (r_clr == CellW'(Cells - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty && !n_ovalid) begin
                    o_q_pop = 1'b1;
                    n_it    = i_q_data;
                    g_ra    = {i_q_data.row, i_q_data.col};
                    m_ra    = {i_q_data.row, i_q_data.col};
                    case (i_q_data.kind)
                        K_LOAD: g_we = 1'b1;
                        K_WORD: begin
                            if (r_len < WordLenW'(MaxWord)) begin
                                w_we  = 1'b1;
                                n_len = r_len + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_q_data.last) begin
                                n_state = S_DISPATCH;
                            end
                        end
                        K_READ:  n_state = S_READ_WAIT;
                        default: ;
                    endcase
                end
            end
            S_READ_WAIT: begin
                g_ra    = {r_it.row, r_it.col};
                m_ra    = {r_it.row, r_it.col};
                n_state = S_READ_MARK;
            end
            S_READ_MARK: begin
                n_res    = '{found: 1'b0, start_row: '0, start_col: '0, direction: '0,
                            cell_char: m_rd ? g_rd : SpaceChar};
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_DISPATCH: begin
                n_res = '0;
                n_r   = '0;
                n_c   = '0;
                n_d   = '0;
                if (r_ovf || r_len == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                n_k  = '0;
                n_pr = $signed({2'b00, r_r});
                n_pc = $signed({2'b00, r_c});
                if (er >= 0 && er < $signed({1'b0, dim}) &&
                    ec >= 0 && ec < $signed({1'b0, dim})) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_CMP;
                    n_k     = '1;
                    n_pr    = '1;
                end
            end
            S_FETCH: n_state = S_CMP;
            S_CMP: begin
                if (r_pr != '1 && g_rd == w_rd) begin
                    if ((WordLenW)'(r_k) + 1'b1 == r_len) begin
                        n_k     = '0;
                        n_pr    = $signed({2'b00, r_r});
                        n_pc    = $signed({2'b00, r_c});
                        n_res   = '{found: 1'b1, start_row: r_r, start_col: r_c,
                                    direction: r_d, cell_char: 8'h00};
                        n_state = S_MARK;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_pr    = r_pr + dir_dr(r_d);
                        n_pc    = r_pc + dir_dc(r_d);
                        n_state = S_FETCH;
                    end
                end else begin
                    n_d     = r_d + 1'b1;
                    n_state = S_DIR;
                    if (r_d == 3'd7) begin
                        if ((DimW+1)'(r_c) + 1'b1 == dim) begin
                            n_c = '0;
                            n_r = r_r + 1'b1;
                            if ((DimW+1)'(r_r) + 1'b1 == dim) begin
                                n_state = S_EMIT;
                            end
                        end else begin
                            n_c = r_c + 1'b1;
                        end
                    end
                end
            end
            S_MARK: begin
                m_we = 1'b1;
                n_k  = r_k + 1'b1;
                n_pr = r_pr + dir_dr(r_d);
                n_pc = r_pc + dir_dc(r_d);
                if ((WordLenW)'(r_k) + 1'b1 == r_len) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_ovalid = 1'b1;
                n_len    = '0;
                n_ovf    = 1'b0;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_empty = !r_ovalid;
    assign o_res   = r_res;
    assign o_idle  = (r_state == S_IDLE);
endmodule

// ===== design/grid_word_search.sv =====
// Word search over a square letter grid, eight directions.
// Input queue: i_push/o_full, one transaction per item (load, word char, read).
// Result queue: o_empty/i_pop; the result ports hold the oldest result.
// Config: i_cfg_valid/o_cfg_ready writes grid_size; ready is high only while
// the back end is idle and its input queue is empty.
// Loads and non-final word characters are handled in the back end's idle state.
// A read item goes through S_READ_WAIT and S_READ_MARK before its result is registered.
// A final word character runs the search: per start cell and direction S_DIR
// checks the end cell against the bounds, and S_CMP drops a direction out of
// bounds; otherwise each character takes an S_FETCH and an S_CMP state, since
// the grid and word memories each give one registered read per cycle.
// A two-entry queue separates intake from the search engine.
// After reset a clearing pass writes the 1024-entry mark store, one entry a
// cycle; input items wait in the queue during that time.
// A stalled result holds the back end; the input queue fills and raises full.
module grid_word_search import gws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_kind,
    input  logic [DimW-1:0]  i_row,
    input  logic [DimW-1:0]  i_col,
    input  logic [7:0]       i_ch,
    input  logic             i_last,
    output logic             o_empty,
    input  logic             i_pop,
    output logic             o_found,
    output logic [DimW-1:0]  o_start_row,
    output logic [DimW-1:0]  o_start_col,
    output logic [2:0]       o_direction,
    output logic [7:0]       o_cell_char,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [SizeW-1:0] i_cfg_data
);
    logic             q_push, q_full, q_empty, q_pop, idle;
    t_item            q_in, q_out;
    t_result          res;
    logic [SizeW-1:0] r_grid_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= SizeW'(MaxDim);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_size <= i_cfg_data;
        end
    end

    assign o_cfg_ready = idle && q_empty;

    gws_front u_front (
        .i_push(i_push), .o_full(o_full),
        .i_kind(i_kind), .i_row(i_row), .i_col(i_col), .i_ch(i_ch), .i_last(i_last),
        .o_q_push(q_push), .o_q_data(q_in), .i_q_full(q_full));

    gws_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_data(q_in),
        .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_data(q_out));

    gws_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(q_empty), .i_q_data(q_out),
        .o_q_pop(q_pop), .i_grid_size(r_grid_size), .o_empty(o_empty),
        .i_pop(i_pop), .o_res(res), .o_idle(idle));

    assign o_found     = res.found;
    assign o_start_row = res.start_row;
    assign o_start_col = res.start_col;
    assign o_direction = res.direction;
    assign o_cell_char = res.cell_char;
endmodule

// ===== design/gws_checker.sv =====
module gws_checker import gws_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_empty,
    input logic            i_pop,
    input logic            o_found,
    input logic [DimW-1:0] o_start_row,
    input logic [DimW-1:0] o_start_col,
    input logic [2:0]      o_direction,
    input logic [7:0]      o_cell_char
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_cell_char) && $stable(o_found))
        else $error("result changed while stalled");
    a_found_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_found |-> o_cell_char == 8'h00)
        else $error("found result carries a char");
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_found |-> o_start_row == '0 && o_start_col == '0 &&
        o_direction == '0)
        else $error("not-found result carries a position");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result after reset");
endmodule

bind grid_word_search gws_checker u_gws_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_empty(o_empty), .i_pop(i_pop),
    .o_found(o_found), .o_start_row(o_start_row), .o_start_col(o_start_col),
    .o_direction(o_direction), .o_cell_char(o_cell_char));
